/* rtl/fl32_pkg.sv */
// package: shared types, constants and modular add for the fletcher-32 checksum
package fl32_pkg;

  localparam int unsigned HALF_W  = 16;
  localparam int unsigned SUM_W   = 2 * HALF_W;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 2;

  localparam logic [HALF_W-1:0] FL_MOD = 16'hffff;

  // valid-byte codes of an item
  localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] CNT_ODD  = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_FULL = 2'd2;

  typedef struct packed {
    logic [HALF_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } item_t;

  // control from the pipeline to the accumulator
  typedef struct packed {
    logic               fire;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } step_t;

  // (a + b) mod 65535 for a, b up to 0xffff: end-around carry, then fold 0xffff to 0
  function automatic logic [HALF_W-1:0] mod_add(input logic [HALF_W-1:0] a,
                                                 input logic [HALF_W-1:0] b);
    logic [HALF_W:0]   t;
    logic [HALF_W-1:0] f;
    t = {1'b0, a} + {1'b0, b};
    f = t[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, t[HALF_W]};
    return (f == FL_MOD) ? '0 : f;
  endfunction

endpackage

/* rtl/fl32_if.sv */
// interfaces: input item, result item and seed write channels
interface fl32_in_if;
  import fl32_pkg::*;
  logic               valid;
  logic               ready;
  logic [HALF_W-1:0]  data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               last;
  modport source  (output valid, data_word, byte_count, last, input ready);
  modport sink    (input valid, data_word, byte_count, last, output ready);
endinterface

interface fl32_out_if;
  import fl32_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] checksum;
  modport source  (output valid, checksum, input ready);
  modport sink    (input valid, checksum, output ready);
endinterface

interface fl32_cfg_if;
  import fl32_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] seed;
  modport source  (output valid, seed, input ready);
  modport sink    (input valid, seed, output ready);
endinterface

/* rtl/fletcher32_checksum.sv */
// top level: streaming fletcher-32 checksum with seed register
//
//  channel     dir  handshake      payload
//  data_in     in   valid/ready    data_word[15:0], byte_count[1:0], last
//  result_out  out  valid/ready    checksum[31:16] = sum two, [15:0] = sum one
//  cfg_in      in   valid/ready    seed[31:0], ready always high
//
// one item per clock while no result is stalled; an item passes an input register,
// then the modular add of both sums lands in the state, or for a last item in the
// result register while the state reloads the seed
// reset clears the seed and both sums to zero, all valids low
// a stalled result holds the pipeline: data_in.ready drops only while a
// result waits and the input register is also full
module fletcher32_checksum
  import fl32_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  fl32_in_if.sink    data_in,
  fl32_out_if.source result_out,
  fl32_cfg_if.sink   cfg_in
);

  // seed register, also reloads the sums on write
  logic [SUM_W-1:0] seed_q;
  logic             seed_load;

  // input stage
  logic  in_valid_q;
  item_t item_q;

  // result stage
  logic             out_valid_q;
  logic [SUM_W-1:0] checksum_q;

  logic             advance;
  step_t            step;
  logic [SUM_W-1:0] checksum_next;

  assign cfg_in.ready = 1'b1;
  assign seed_load    = cfg_in.valid;

  // the result stage can take a new value when empty or being drained
  assign advance       = !out_valid_q || result_out.ready;
  assign data_in.ready = !in_valid_q || advance;

  assign step.fire       = in_valid_q && advance;
  assign step.byte_count = item_q.byte_count;
  assign step.last       = item_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_load) begin
      seed_q <= cfg_in.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (data_in.ready) begin
      in_valid_q <= data_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_in.valid && data_in.ready) begin
      item_q.data_word  <= data_in.data_word;
      item_q.byte_count <= data_in.byte_count;
      item_q.last       <= data_in.last;
    end
  end

  fl32_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (item_q.data_word),
    .seed_load_i (seed_load),
    .seed_i      (seed_load ? cfg_in.seed : seed_q),
    .checksum_o  (checksum_next)
  );

  // only a last item produces a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step.fire && step.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.fire && step.last) begin
      checksum_q <= checksum_next;
    end
  end

  assign result_out.valid    = out_valid_q;
  assign result_out.checksum = checksum_q;

endmodule

/* rtl/fl32_accum.sv */
// accumulator: sum one / sum two state and the one-step modular update
module fl32_accum
  import fl32_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_t             step_i,
  input  logic [HALF_W-1:0] word_i,
  input  logic              seed_load_i,
  input  logic [SUM_W-1:0]  seed_i,
  output logic [SUM_W-1:0]  checksum_o
);

  logic [HALF_W-1:0] sum_one_q, sum_one_d;
  logic [HALF_W-1:0] sum_two_q, sum_two_d;
  logic [HALF_W-1:0] word;
  logic [HALF_W-1:0] one_upd, two_upd;

  // odd tail keeps only the earlier byte; count 3 is taken as a full word
  assign word = (step_i.byte_count == CNT_ODD) ?
                {{(HALF_W-BYTE_W){1'b0}}, word_i[BYTE_W-1:0]} : word_i;

  assign one_upd = mod_add(sum_one_q, word);
  assign two_upd = mod_add(sum_two_q, one_upd);

  always_comb begin
    unique case (step_i.byte_count)
      CNT_NONE: begin
        sum_one_d = sum_one_q;
        sum_two_d = sum_two_q;
      end
      default: begin
        sum_one_d = one_upd;
        sum_two_d = two_upd;
      end
    endcase
  end

  // sums after this item, emitted on a last item
  assign checksum_o = {sum_two_d, sum_one_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_one_q <= '0;
      sum_two_q <= '0;
    end else if (seed_load_i || (step_i.fire && step_i.last)) begin
      sum_one_q <= seed_i[HALF_W-1:0];
      sum_two_q <= seed_i[SUM_W-1:HALF_W];
    end else if (step_i.fire) begin
      sum_one_q <= sum_one_d;
      sum_two_q <= sum_two_d;
    end
  end

endmodule

/* rtl/fl32_checker.sv */
// checker: port-level assertions for the fletcher-32 checksum, bound to the top level
module fl32_checker
  import fl32_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SUM_W-1:0] out_checksum_i,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // seed writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("seed write refused");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_checksum_i))
    else $error("result changed while stalled");

endmodule

bind fletcher32_checksum fl32_checker u_fl32_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (data_in.ready),
  .out_valid_i    (result_out.valid),
  .out_ready_i    (result_out.ready),
  .out_checksum_i (result_out.checksum),
  .cfg_valid_i    (cfg_in.valid),
  .cfg_ready_i    (cfg_in.ready)
);

/* tb/sv/tb_top.sv */
// testbench top: fletcher-32 checksum stream checked against a predictor kept in the bench
`timescale 1ns / 100ps

module tb_top;
  import fl32_pkg::*;

  // unused count code, the block takes it as a full word
  localparam logic [COUNT_W-1:0] CNT_UNDEF = 2'd3;

  // an item taken by the block passes the input register before it reaches the sums;
  // the settle wait covers any non-last item still in flight
  localparam int unsigned PIPE_SETTLE     = 6;
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS     = 220;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned TAIL_ITEMS      = 150;
  localparam int unsigned REPORT_CAP      = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fl32_in_if  data_ch ();
  fl32_out_if result_ch ();
  fl32_cfg_if seed_ch ();

  fletcher32_checksum dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_in    (data_ch),
    .result_out (result_ch),
    .cfg_in     (seed_ch)
  );

  // predictor state: the seed to chain from and the two running sums
  logic [SUM_W-1:0]  chain_seed;
  logic [HALF_W-1:0] run_one;
  logic [HALF_W-1:0] run_two;

  // checksums that the block still owes, oldest first
  logic [SUM_W-1:0] expected_checksums[$];

  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_off_len = 0;

  // random idling on the sender and receiver side
  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  // (a + b) mod 65535, a or b may be the unreduced value 0xffff
  function automatic logic [HALF_W-1:0] add_mod_ffff(input logic [HALF_W-1:0] a,
                                                     input logic [HALF_W-1:0] b);
    logic [31:0] total;
    total = a + b;
    total = total % FL_MOD;
    return total[HALF_W-1:0];
  endfunction

  // low half of the seed starts sum one, high half sum two
  function automatic void reload_sums();
    run_one = chain_seed[HALF_W-1:0];
    run_two = chain_seed[SUM_W-1:HALF_W];
  endfunction

  // fold one accepted item into the sums; a last item closes the message
  function automatic void fold_item(input item_t it);
    logic [HALF_W-1:0] word;
    word = it.data_word;
    if (it.byte_count != CNT_NONE) begin
      // odd tail: only the earlier byte counts, high byte taken as zero
      if (it.byte_count == CNT_ODD) begin
        word = {{(HALF_W-BYTE_W){1'b0}}, word[BYTE_W-1:0]};
      end
      run_one = add_mod_ffff(run_one, word);
      run_two = add_mod_ffff(run_two, run_one);
    end
    if (it.last) begin
      // an empty message hands back the seed as written, halves not reduced
      expected_checksums.push_back({run_two, run_one});
      reload_sums();
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // monitors and checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
    if (error_count < REPORT_CAP) begin
      $display("%0t ns mismatch, %s: want %08h got %08h", $realtime, what, want, got);
    end
    error_count++;
  endtask

  // every item the block takes goes through the predictor
  always @(posedge clk_i) begin
    if (rst_ni && data_ch.valid && data_ch.ready) begin
      fold_item({data_ch.data_word, data_ch.byte_count, data_ch.last});
    end
  end

  // every checksum the block hands out is held against the oldest one owed
  always @(posedge clk_i) begin : result_check
    logic [SUM_W-1:0] want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_checksums.size() == 0) begin
        report_mismatch("checksum with none owed", '0, result_ch.checksum);
      end else begin
        want = expected_checksums.pop_front();
        if (result_ch.checksum !== want) begin
          report_mismatch("checksum", want, result_ch.checksum);
        end
      end
    end
  end

  // cycles in which no channel moves an item
  always @(posedge clk_i) begin
    if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (seed_ch.valid && seed_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t ns no progress for %0d cycles", $realtime, QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // result receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned n;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_len > 0) begin
        // long hold-off so the block fills up and stalls its input
        n = hold_off_len;
        hold_off_len = 0;
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        result_ch.ready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------------------

  // offer one item, maybe after a gap, and wait until the block takes it
  task automatic send_item(input logic [HALF_W-1:0] word, input logic [COUNT_W-1:0] count,
                           input logic last);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      data_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    data_ch.valid      <= 1'b1;
    data_ch.data_word  <= word;
    data_ch.byte_count <= count;
    data_ch.last       <= last;
    do @(posedge clk_i); while (!(data_ch.valid && data_ch.ready));
  endtask

  // well formed: full words, with an odd or empty tail only on the last item
  function automatic item_t random_item(input logic last, input bit well_formed);
    item_t it;
    int unsigned pick;
    it.data_word = HALF_W'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      it.data_word = $urandom_range(0, 1) ? '1 : '0;
    end
    pick = $urandom_range(0, 15);
    if (well_formed) begin
      it.byte_count = CNT_FULL;
      if (last && pick < 4) it.byte_count = CNT_ODD;
      if (last && pick == 4) it.byte_count = CNT_NONE;
    end else begin
      case (pick)
        0, 1:    it.byte_count = CNT_NONE;
        2, 3, 4: it.byte_count = CNT_ODD;
        5, 6:    it.byte_count = CNT_UNDEF;
        default: it.byte_count = CNT_FULL;
      endcase
    end
    it.last = last;
    return it;
  endfunction

  // stop offering, wait for every owed checksum, then let the pipeline settle
  task automatic drain();
    data_ch.valid <= 1'b0;
    // let the item just taken reach the predictor before the queue is checked
    @(posedge clk_i);
    while (expected_checksums.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  // seed is only written with the block idle; the write also restarts the sums
  task automatic write_seed(input logic [SUM_W-1:0] value);
    drain();
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= value;
    do @(posedge clk_i); while (!(seed_ch.valid && seed_ch.ready));
    seed_ch.valid <= 1'b0;
    chain_seed = value;
    reload_sums();
  endtask

  function automatic logic [SUM_W-1:0] pick_seed();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h0000_ffff;
      3:       return 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  // messages of random length, mostly short, now and then a long one
  task automatic send_messages(input int unsigned total);
    int unsigned sent;
    int unsigned len;
    bit          well_formed;
    item_t       it;
    sent = 0;
    while (sent < total) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      well_formed = ($urandom_range(0, 4) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        it = random_item(i == len - 1, well_formed);
        send_item(it.data_word, it.byte_count, it.last);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // seed is zero after reset
  task automatic test_reset_state();
    send_item(16'h0000, CNT_NONE, 1'b1);
    send_item(16'hffff, CNT_FULL, 1'b1);
    send_item(16'h0001, CNT_FULL, 1'b0);
    send_item(16'h8000, CNT_FULL, 1'b1);
  endtask

  // odd byte in the middle, undefined count, empty item inside a message
  task automatic test_byte_counts();
    send_item(16'h1234, CNT_ODD,   1'b0);
    send_item(16'habcd, CNT_UNDEF, 1'b0);
    send_item(16'hff00, CNT_NONE,  1'b0);
    send_item(16'h00ff, CNT_FULL,  1'b0);
    send_item(16'hffff, CNT_ODD,   1'b1);
    send_item(16'hffff, CNT_UNDEF, 1'b1);
  endtask

  // extreme seeds, empty messages return them unreduced
  task automatic test_seed_extremes();
    write_seed(32'hffff_ffff);
    send_item(16'h0000, CNT_NONE, 1'b1);
    send_item(16'h0001, CNT_FULL, 1'b1);
    write_seed(32'h0000_ffff);
    send_item(16'hffff, CNT_FULL, 1'b0);
    send_item(16'h0000, CNT_NONE, 1'b1);
    write_seed(32'hffff_0000);
    send_item(16'h5a5a, CNT_ODD, 1'b1);
    write_seed(32'h0000_0000);
    send_item(16'h0000, CNT_NONE, 1'b1);
  endtask

  // a seed write in the middle of a message throws away the partial sums
  task automatic test_seed_restart();
    write_seed($urandom);
    send_item(16'hbeef, CNT_FULL, 1'b0);
    send_item(16'h0042, CNT_ODD,  1'b0);
    send_item(16'hffff, CNT_FULL, 1'b0);
    write_seed(32'h1234_5678);
    send_item(16'h0000, CNT_NONE, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    item_t it;
    write_seed(pick_seed());
    hold_off_len = HOLD_OFF_CYCLES;
    for (int unsigned i = 0; i < 48; i++) begin
      it = random_item(i % 4 == 3, 1'b1);
      send_item(it.data_word, it.byte_count, it.last);
    end
  endtask

  // random messages with both sides idling, a new seed for each phase
  task automatic test_random_messages();
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      write_seed(pick_seed());
      send_messages(PHASE_ITEMS);
    end
  endtask

  // back-to-back items with a receiver that never stalls
  task automatic test_full_rate();
    write_seed(pick_seed());
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_messages(TAIL_ITEMS);
  endtask

  initial begin : run
    data_ch.valid      = 1'b0;
    data_ch.data_word  = '0;
    data_ch.byte_count = CNT_NONE;
    data_ch.last       = 1'b0;
    seed_ch.valid      = 1'b0;
    seed_ch.seed       = '0;
    chain_seed         = '0;
    reload_sums();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_byte_counts();
    test_seed_extremes();
    test_seed_restart();
    test_backpressure();
    test_random_messages();
    test_full_rate();

    drain();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* fletcher32_checksum.f */
rtl/fl32_pkg.sv
rtl/fl32_if.sv
rtl/fl32_accum.sv
rtl/fletcher32_checksum.sv
rtl/fl32_checker.sv
tb/sv/tb_top.sv
